FILE: design/tcw_pkg.sv
package tcw_pkg;

	localparam int CELL_W = 16;

	localparam logic [1:0] CMD_PUT        = 2'd0;
	localparam logic [1:0] CMD_SET_CURSOR = 2'd1;
	localparam logic [1:0] CMD_CLEAR      = 2'd2;
	localparam logic [1:0] CMD_READ       = 2'd3;

	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_RETURN    = 8'h0D;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;

	localparam logic CFG_ATTR   = 1'b0;
	localparam logic CFG_ENABLE = 1'b1;

	localparam logic [7:0] ATTR_RESET = 8'h0F;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_BSWR,
		ST_SCROLL,
		ST_BLANK,
		ST_CLEAR
	} tcw_state_t;

endpackage

FILE: design/tcw_cell_ram.sv
module tcw_cell_ram
	import tcw_pkg::*;
#(
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [CELL_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/text_console_writer.sv
// Text console writer. An item is taken when start is high and busy is low; its result shows
// on done for one cycle and must be taken then. Put of a printable byte, return, newline, set
// cursor, read cell, a put while disabled and a backspace at column zero are handled when taken
// (unless the put scrolls), so done shows in the cycle after and a new start can be taken in
// the done cycle. Any other backspace reads the cell when taken and writes it back in ST_BSWR,
// through the single read and single write port of the screen memory. A newline or a wrap on
// the bottom row scrolls: every cell moves up one row at one cell per cycle, then the bottom
// row is blanked. Clear screen writes every cell once. After reset busy stays high while the
// memory is zeroed; configuration writes are taken during that pass.
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [7:0]  char_code,
	input  logic [6:0]  col,
	input  logic [4:0]  row,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        done,
	output logic [10:0] cursor_position,
	output logic        scrolled,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_attr
);

	localparam int CELLS     = COLUMNS * ROWS;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int BOTTOM    = COLUMNS * (ROWS - 1);
	localparam int COPY_LAST = BOTTOM - 1;

	tcw_state_t state_q, state_d;

	logic [6:0]        cur_col_q;
	logic [4:0]        cur_row_q;
	logic [7:0]        attr_q;
	logic              en_q;
	logic [ADDR_W-1:0] ptr_q;
	logic              copy_vld_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              done_q, scrolled_q, rdsel_q;

	logic              accept;
	logic              is_put, put_bs, bs_go, put_cr, put_lf, put_chr;
	logic              at_right, at_bottom, need_scroll, ptr_last, blank_end;
	logic [6:0]        col_c;
	logic [4:0]        row_c;
	logic [ADDR_W-1:0] cur_addr, bs_addr, rd_cell_addr;

	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;

	assign accept    = start && (state_q == ST_IDLE);
	assign is_put    = (cmd == CMD_PUT) && en_q;
	assign put_bs    = is_put && (char_code == CH_BACKSPACE);
	assign bs_go     = put_bs && (cur_col_q != 7'd0);
	assign put_cr    = is_put && (char_code == CH_RETURN);
	assign put_lf    = is_put && (char_code == CH_NEWLINE);
	assign put_chr   = is_put && !put_bs && !put_cr && !put_lf;
	assign at_right  = cur_col_q == 7'(COLUMNS - 1);
	assign at_bottom = cur_row_q == 5'(ROWS - 1);
	assign need_scroll = at_bottom && (put_lf || (put_chr && at_right));
	assign ptr_last  = ptr_q == ADDR_W'(CELLS - 1);
	assign blank_end = (state_q == ST_BLANK) && !copy_vld_s1 && ptr_last;

	assign col_c = ({1'b0, col} >= 8'(COLUMNS)) ? 7'(COLUMNS - 1) : col;
	assign row_c = ({1'b0, row} >= 6'(ROWS)) ? 5'(ROWS - 1) : row;

	assign cur_addr     = ADDR_W'(ADDR_W'(cur_row_q) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_q));
	assign bs_addr      = ADDR_W'(cur_addr - ADDR_W'(1));
	assign rd_cell_addr = ADDR_W'(ADDR_W'(row_c) * ADDR_W'(COLUMNS) + ADDR_W'(col_c));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (ptr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_CLEAR) state_d = ST_CLEAR;
					else if (bs_go) state_d = ST_BSWR;
					else if (need_scroll) state_d = ST_SCROLL;
				end
			end
			ST_BSWR: state_d = ST_IDLE;
			ST_SCROLL: begin
				if (ptr_q == ADDR_W'(COPY_LAST)) state_d = ST_BLANK;
			end
			ST_BLANK: begin
				if (blank_end) state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				if (ptr_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = {attr_q, 8'h00};
		ram_re    = 1'b0;
		ram_raddr = rd_cell_addr;
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				if (accept && cmd == CMD_READ) begin
					ram_re = 1'b1;
				end
				if (accept && bs_go) begin
					ram_re    = 1'b1;
					ram_raddr = bs_addr;
				end
				if (accept && put_chr) begin
					ram_we    = 1'b1;
					ram_waddr = cur_addr;
					ram_wdata = {attr_q, char_code};
				end
			end
			ST_BSWR: begin
				ram_we    = 1'b1;
				ram_waddr = addr_s1;
				ram_wdata = {ram_rdata[15:8], 8'h00};
			end
			ST_SCROLL: begin
				ram_re    = 1'b1;
				ram_raddr = ADDR_W'(ptr_q + ADDR_W'(COLUMNS));
				if (copy_vld_s1) begin
					ram_we    = 1'b1;
					ram_waddr = addr_s1;
					ram_wdata = ram_rdata;
				end
			end
			ST_BLANK: begin
				ram_we = 1'b1;
				if (copy_vld_s1) begin
					ram_waddr = addr_s1;
					ram_wdata = ram_rdata;
				end
			end
			ST_CLEAR: ram_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			ptr_q       <= '0;
			copy_vld_s1 <= 1'b0;
			done_q      <= 1'b0;
			scrolled_q  <= 1'b0;
			rdsel_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			copy_vld_s1 <= state_q == ST_SCROLL;
			done_q      <= (accept && cmd != CMD_CLEAR && !bs_go && !need_scroll)
				|| (state_q == ST_BSWR)
				|| (state_q == ST_CLEAR && ptr_last)
				|| blank_end;
			scrolled_q  <= blank_end;
			rdsel_q     <= accept && cmd == CMD_READ;
			case (state_q)
				ST_INIT, ST_CLEAR: ptr_q <= ADDR_W'(ptr_q + ADDR_W'(1));
				ST_IDLE: ptr_q <= '0;
				ST_SCROLL: begin
					if (ptr_q == ADDR_W'(COPY_LAST)) ptr_q <= ADDR_W'(BOTTOM);
					else ptr_q <= ADDR_W'(ptr_q + ADDR_W'(1));
				end
				ST_BLANK: begin
					if (!copy_vld_s1) ptr_q <= ADDR_W'(ptr_q + ADDR_W'(1));
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= (state_q == ST_SCROLL) ? ptr_q : bs_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
		end else if (accept) begin
			case (cmd)
				CMD_PUT: begin
					if (bs_go) begin
						cur_col_q <= cur_col_q - 7'd1;
					end else if (put_cr) begin
						cur_col_q <= '0;
					end else if (put_lf) begin
						cur_col_q <= '0;
						if (!at_bottom) cur_row_q <= cur_row_q + 5'd1;
					end else if (put_chr) begin
						if (at_right) begin
							cur_col_q <= '0;
							if (!at_bottom) cur_row_q <= cur_row_q + 5'd1;
						end else begin
							cur_col_q <= cur_col_q + 7'd1;
						end
					end
				end
				CMD_SET_CURSOR: begin
					cur_col_q <= col_c;
					cur_row_q <= row_c;
				end
				CMD_CLEAR: begin
					cur_col_q <= '0;
					cur_row_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
			en_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ATTR:   attr_q <= cfg_data;
				CFG_ENABLE: en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tcw_cell_ram #(
		.DEPTH  (CELLS),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign busy            = state_q != ST_IDLE;
	assign done            = done_q;
	assign scrolled        = scrolled_q;
	assign cursor_position = 11'(cur_addr);
	assign cell_char       = rdsel_q ? ram_rdata[7:0] : 8'h00;
	assign cell_attr       = rdsel_q ? ram_rdata[15:8] : 8'h00;

`ifndef SYNTHESIS
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_col_q < 7'(COLUMNS))
		else $error("cursor column out of range");

	a_copy_state: assert property (@(posedge clk) disable iff (!arst_n)
		copy_vld_s1 |-> (state_q == ST_SCROLL || state_q == ST_BLANK))
		else $error("copy beat outside scroll");

	a_scroll_done: assert property (@(posedge clk) disable iff (!arst_n)
		scrolled_q |-> done_q && state_q == ST_IDLE && cur_row_q == 5'(ROWS - 1))
		else $error("scroll result without done or off bottom row");

	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == CMD_READ |=> done_q && !scrolled_q)
		else $error("read cell result missing");
`endif

endmodule
